// ===== rtl/core/wheel_key_tap_long_press_classifier_top_defines.svh =====
// Assertion macros for the steering wheel key classifier.
`ifndef WHEEL_KEY_TAP_LONG_PRESS_CLASSIFIER_TOP_DEFINES_SVH
`define WHEEL_KEY_TAP_LONG_PRESS_CLASSIFIER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the clock, off during reset.
`define WKTLP_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("wktlp: same-cycle check failed");

// Next-cycle implication, sampled on the clock, off during reset.
`define WKTLP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("wktlp: next-cycle check failed");

`endif

// ===== rtl/core/wktlp_pkg.sv =====
// Shared types, codes and decode functions of the wheel key classifier.
package wktlp_pkg;

   localparam int FrameIdWidth  = 11;
   localparam int ByteWidth     = 8;
   localparam int TimeWidth     = 32;
   localparam int HoldWidth     = 16;
   localparam int KeyWidth      = 3;
   localparam int EventWidth    = 4;
   localparam int PageWidth     = 2;
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 16;

   typedef logic [FrameIdWidth-1:0] frame_id_type;
   typedef logic [ByteWidth-1:0]    byte_type;
   typedef logic [TimeWidth-1:0]    time_ms_type;
   typedef logic [HoldWidth-1:0]    hold_ms_type;
   typedef logic [KeyWidth-1:0]     key_type;
   typedef logic [EventWidth-1:0]   event_type;
   typedef logic [PageWidth-1:0]    page_type;
   typedef logic [CsrIndexWidth-1:0] csr_index_type;
   typedef logic [CsrDataWidth-1:0]  csr_data_type;

   // Register indexes
   localparam csr_index_type CsrWatchedFrameId = 2'd0;
   localparam csr_index_type CsrLongPressMs    = 2'd1;

   localparam frame_id_type WatchedFrameIdReset = 11'h1CA;
   localparam hold_ms_type  LongPressMsReset    = 16'd1000;

   // Raw key codes on the bus
   localparam byte_type CodeUp      = 8'h01;
   localparam byte_type CodeDown    = 8'h02;
   localparam byte_type CodeTelUp   = 8'h40;
   localparam byte_type CodeTelDown = 8'h80;

   // Raw page codes on the bus
   localparam byte_type CodePageAudio = 8'h03;
   localparam byte_type CodePageTel   = 8'h05;

   // Decoded keys
   localparam key_type KeyNone    = 3'd0;
   localparam key_type KeyUp      = 3'd1;
   localparam key_type KeyDown    = 3'd2;
   localparam key_type KeyTelUp   = 3'd3;
   localparam key_type KeyTelDown = 3'd4;

   localparam event_type EventNone  = 4'd0;
   localparam event_type LongOffset = 4'd4;

   // Decoded pages
   localparam page_type PageAudio = 2'd0;
   localparam page_type PageTel   = 2'd1;
   localparam page_type PageOther = 2'd2;

   function automatic key_type decode_key(input byte_type code);
      key_type k;
      case (code)
         CodeUp:      k = KeyUp;
         CodeDown:    k = KeyDown;
         CodeTelUp:   k = KeyTelUp;
         CodeTelDown: k = KeyTelDown;
         default:     k = KeyNone;
      endcase
      return k;
   endfunction

   function automatic page_type decode_page(input byte_type code);
      page_type p;
      case (code)
         CodePageAudio: p = PageAudio;
         CodePageTel:   p = PageTel;
         default:       p = PageOther;
      endcase
      return p;
   endfunction

endpackage

// ===== rtl/core/wheel_key_tap_long_press_classifier_top.sv =====
// Steering wheel key classifier: turns key frames into tap and long-press events.
//
// Takes one bus frame per clock while req_stall is low and returns exactly one
// result per frame, registered, in the cycle after the request transfer; the only
// storage between the two sides is the result register, so a stalled result holds
// off the next request only while it waits. Frames with another identifier return
// page_valid 0 and no event and leave the press tracker alone. A key going from
// zero to nonzero starts a press; a release before the hold time gives a tap event,
// and the first frame with the key still held after more than long_press_ms (time
// wraps modulo 2^32) gives one long event. All state but the result payload is set
// by reset; there is no start-up sweep, and the CSR port is always ready.
`include "wheel_key_tap_long_press_classifier_top_defines.svh"

module wheel_key_tap_long_press_classifier_top
   import wktlp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,

   input  logic          req_valid,
   output logic          req_stall,
   input  frame_id_type  req_frame_id,
   input  byte_type      req_page_byte,
   input  byte_type      req_key_byte,
   input  time_ms_type   req_now_ms,

   output logic          rsp_valid,
   input  logic          rsp_stall,
   output event_type     rsp_key_event,
   output logic          rsp_page_valid,
   output page_type      rsp_page,

   input  logic          csr_valid,
   output logic          csr_ready,
   input  csr_index_type csr_index,
   input  csr_data_type  csr_data
);

   frame_id_type watched_id_ff;
   hold_ms_type  long_press_ff;

   logic        held_pending_ff, held_pending_in;
   key_type     latched_key_ff, latched_key_in;
   logic        prev_key_held_ff, prev_key_held_in;
   time_ms_type press_start_ff, press_start_in;

   logic        rsp_valid_ff, rsp_valid_in;
   event_type   key_event_ff, key_event_in;
   logic        page_valid_ff, page_valid_in;
   page_type    page_ff, page_in;

   logic        req_xfer;
   logic        id_match;
   logic        key_nz;
   time_ms_type elapsed;
   logic        long_hit;

   assign csr_ready = 1'b1;
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_xfer  = req_valid && !req_stall;

   assign id_match = (req_frame_id == watched_id_ff);
   assign key_nz   = (req_key_byte != '0);
   assign elapsed  = req_now_ms - press_start_ff;
   assign long_hit = held_pending_ff && (elapsed > {{(TimeWidth-HoldWidth){1'b0}}, long_press_ff});

   always_comb begin
      held_pending_in  = held_pending_ff;
      latched_key_in   = latched_key_ff;
      prev_key_held_in = prev_key_held_ff;
      press_start_in   = press_start_ff;
      key_event_in     = EventNone;
      page_valid_in    = 1'b0;
      page_in          = PageAudio;
      if (id_match) begin
         page_valid_in    = 1'b1;
         page_in          = decode_page(req_page_byte);
         prev_key_held_in = key_nz;
         if (key_nz && !prev_key_held_ff) begin
            // new press: latch key and start time
            held_pending_in = 1'b1;
            press_start_in  = req_now_ms;
            latched_key_in  = decode_key(req_key_byte);
         end else if (key_nz) begin
            if (long_hit) begin
               held_pending_in = 1'b0;
               if (latched_key_ff != KeyNone) begin
                  key_event_in = event_type'(latched_key_ff) + LongOffset;
               end
            end
         end else if (held_pending_ff) begin
            // released before the hold time: tap
            held_pending_in = 1'b0;
            key_event_in    = event_type'(latched_key_ff);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (req_xfer) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         watched_id_ff    <= WatchedFrameIdReset;
         long_press_ff    <= LongPressMsReset;
         held_pending_ff  <= 1'b0;
         latched_key_ff   <= KeyNone;
         prev_key_held_ff <= 1'b0;
         press_start_ff   <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CsrWatchedFrameId: watched_id_ff <= csr_data[FrameIdWidth-1:0];
               CsrLongPressMs:    long_press_ff <= csr_data[HoldWidth-1:0];
               default:           ;
            endcase
         end
         if (req_xfer) begin
            held_pending_ff  <= held_pending_in;
            latched_key_ff   <= latched_key_in;
            prev_key_held_ff <= prev_key_held_in;
            press_start_ff   <= press_start_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload: load on request transfer only
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         key_event_ff  <= key_event_in;
         page_valid_ff <= page_valid_in;
         page_ff       <= page_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_key_event  = key_event_ff;
   assign rsp_page_valid = page_valid_ff;
   assign rsp_page       = page_ff;

   `WKTLP_ASSERT_SAME(a_hold_on_stall, rsp_valid && rsp_stall, !req_xfer)
   `WKTLP_ASSERT_NEXT(a_no_match_no_event, req_xfer && !id_match,
                      rsp_valid && !rsp_page_valid && rsp_key_event == EventNone)
   `WKTLP_ASSERT_NEXT(a_event_needs_pending, req_xfer && !held_pending_ff,
                      rsp_key_event == EventNone)

endmodule

// ===== tb/wktlp_checker.sv =====
// Checker for the wheel key classifier: predicts every result and compares it on the rsp channel.
module wktlp_checker
   import wktlp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,

   input  logic          req_valid,
   input  logic          req_stall,
   input  frame_id_type  req_frame_id,
   input  byte_type      req_page_byte,
   input  byte_type      req_key_byte,
   input  time_ms_type   req_now_ms,

   input  logic          rsp_valid,
   input  logic          rsp_stall,
   input  event_type     rsp_key_event,
   input  logic          rsp_page_valid,
   input  page_type      rsp_page,

   input  logic          csr_valid,
   input  logic          csr_ready,
   input  csr_index_type csr_index,
   input  csr_data_type  csr_data,

   output int            fail_count,
   output int            outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      event_type key_event;
      logic      page_valid;
      page_type  page;
   } key_result_type;

   // Shadow of the block's registers and press tracker
   frame_id_type watched_id;
   hold_ms_type  hold_ms;
   logic         press_pending;
   key_type      press_key;
   byte_type     last_key_byte;
   time_ms_type  press_ms;

   key_result_type pending_results[$];
   key_result_type oldest;

   function automatic key_result_type classify_frame(input frame_id_type fid, input byte_type pg,
                                                     input byte_type key, input time_ms_type now);
      key_result_type res;
      time_ms_type    elapsed;
      res = '0;
      if (fid != watched_id) return res;
      elapsed = now - press_ms;
      if (key != '0 && last_key_byte == '0) begin
         press_pending = 1'b1;
         press_ms      = now;
         case (key)
            CodeUp:      press_key = KeyUp;
            CodeDown:    press_key = KeyDown;
            CodeTelUp:   press_key = KeyTelUp;
            CodeTelDown: press_key = KeyTelDown;
            default:     press_key = KeyNone;
         endcase
      end else if (key != '0) begin
         // still held, possibly with another code: fire the long event once
         if (press_pending && elapsed > time_ms_type'(hold_ms)) begin
            press_pending = 1'b0;
            if (press_key != KeyNone) res.key_event = event_type'(press_key) + LongOffset;
         end
      end else if (press_pending) begin
         press_pending = 1'b0;
         res.key_event = event_type'(press_key);
      end
      last_key_byte  = key;
      res.page_valid = 1'b1;
      case (pg)
         CodePageAudio: res.page = PageAudio;
         CodePageTel:   res.page = PageTel;
         default:       res.page = PageOther;
      endcase
      return res;
   endfunction

   task automatic record_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("%0t: MISMATCH %s", $realtime, msg);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         watched_id    = WatchedFrameIdReset;
         hold_ms       = LongPressMsReset;
         press_pending = 1'b0;
         press_key     = KeyNone;
         last_key_byte = '0;
         press_ms      = '0;
         pending_results.delete();
         fail_count    = 0;
      end else begin
         // compare first: a result at this edge belongs to an earlier request
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               record_failure($sformatf("unexpected result event=%0d page_valid=%0d page=%0d",
                                        rsp_key_event, rsp_page_valid, rsp_page));
            end else begin
               oldest = pending_results.pop_front();
               if (rsp_key_event !== oldest.key_event || rsp_page_valid !== oldest.page_valid ||
                   rsp_page !== oldest.page)
                  record_failure($sformatf(
                     {"expected event=%0d page_valid=%0d page=%0d, ",
                      "got event=%0d page_valid=%0d page=%0d"},
                     oldest.key_event, oldest.page_valid, oldest.page,
                     rsp_key_event, rsp_page_valid, rsp_page));
            end
         end
         if (req_valid && !req_stall)
            pending_results.push_back(classify_frame(req_frame_id, req_page_byte,
                                                     req_key_byte, req_now_ms));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CsrWatchedFrameId: watched_id = csr_data[FrameIdWidth-1:0];
               CsrLongPressMs:    hold_ms    = csr_data;
               default: ;
            endcase
         end
      end
      outstanding = pending_results.size();
   end

endmodule

// ===== tb/tb_wheel_key_tap_long_press_classifier_top.sv =====
// Testbench top for the wheel key classifier: clock, reset, stimulus, watchdog and verdict.
module tb_wheel_key_tap_long_press_classifier_top;
   import wktlp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int            WatchdogLimit = 2000;
   localparam int            PhaseItems    = 250;
   localparam int            NumPhases     = 6;
   localparam csr_index_type CsrSpareA     = 2'd2;
   localparam csr_index_type CsrSpareB     = 2'd3;

   logic          clock          = 1'b0;
   logic          reset          = 1'b1;
   logic          req_valid      = 1'b0;
   logic          req_stall;
   frame_id_type  req_frame_id   = '0;
   byte_type      req_page_byte  = '0;
   byte_type      req_key_byte   = '0;
   time_ms_type   req_now_ms     = '0;
   logic          rsp_valid;
   logic          rsp_stall      = 1'b0;
   event_type     rsp_key_event;
   logic          rsp_page_valid;
   page_type      rsp_page;
   logic          csr_valid      = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index      = '0;
   csr_data_type  csr_data       = '0;

   int fail_count;
   int outstanding;

   frame_id_type cfg_id   = WatchedFrameIdReset;
   hold_ms_type  cfg_hold = LongPressMsReset;
   time_ms_type  cur_ms;
   bit           no_gaps  = 1'b0;
   int           stall_left = 0;
   int unsigned  stall_pick;
   int           quiet_cycles = 0;

   always #1 clock = ~clock;

   wheel_key_tap_long_press_classifier_top dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_frame_id, .req_page_byte, .req_key_byte, .req_now_ms,
      .rsp_valid, .rsp_stall, .rsp_key_event, .rsp_page_valid, .rsp_page,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   wktlp_checker scoreboard (
      .clock, .reset,
      .req_valid, .req_stall, .req_frame_id, .req_page_byte, .req_key_byte, .req_now_ms,
      .rsp_valid, .rsp_stall, .rsp_key_event, .rsp_page_valid, .rsp_page,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .fail_count, .outstanding
   );

   // Receiver back-pressure: free runs, short stalls, a few long ones
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_pick = $urandom_range(0, 99);
         if (stall_pick < 45) begin
            rsp_stall  <= 1'b0;
            stall_left = $urandom_range(1, 20);
         end else if (stall_pick < 50) begin
            rsp_stall  <= 1'b0;
            stall_left = $urandom_range(100, 300);
         end else if (stall_pick < 90) begin
            rsp_stall  <= 1'b1;
            stall_left = $urandom_range(1, 3);
         end else begin
            rsp_stall  <= 1'b1;
            stall_left = $urandom_range(10, 40);
         end
      end else begin
         stall_left--;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Hold the frame until the transfer, return at the next falling edge
   task automatic send_frame(input frame_id_type fid, input byte_type pg, input byte_type key,
                             input time_ms_type now);
      req_valid     <= 1'b1;
      req_frame_id  <= fid;
      req_page_byte <= pg;
      req_key_byte  <= key;
      req_now_ms    <= now;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic sender_gap();
      int unsigned r;
      int unsigned n;
      r = $urandom_range(0, 99);
      if (r < 60) n = 0;
      else if (r < 92) n = $urandom_range(1, 3);
      else n = $urandom_range(10, 40);
      if (!no_gaps && n != 0) begin
         req_valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   // Stop sending and wait for every outstanding result
   task automatic drain();
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input csr_data_type data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic set_config(input frame_id_type id_val, input hold_ms_type hold_val);
      drain();
      csr_write(CsrWatchedFrameId, {5'($urandom), id_val});
      csr_write(CsrLongPressMs, hold_val);
      // unused indexes must leave both registers alone
      csr_write(CsrSpareA, csr_data_type'($urandom));
      csr_write(CsrSpareB, csr_data_type'($urandom));
      csr_valid <= 1'b0;
      cfg_id   = id_val;
      cfg_hold = hold_val;
   endtask

   task automatic send_random_frame();
      frame_id_type fid;
      byte_type     pg;
      byte_type     key;
      int unsigned  r;
      r = $urandom_range(0, 99);
      fid = (r < 82) ? cfg_id : frame_id_type'($urandom);
      r = $urandom_range(0, 99);
      if (r < 35) pg = CodePageAudio;
      else if (r < 60) pg = CodePageTel;
      else pg = byte_type'($urandom);
      r = $urandom_range(0, 99);
      if (r < 30) begin
         key = '0;
      end else if (r < 80) begin
         case ($urandom_range(0, 3))
            0:       key = CodeUp;
            1:       key = CodeDown;
            2:       key = CodeTelUp;
            default: key = CodeTelDown;
         endcase
      end else begin
         key = byte_type'($urandom);
      end
      // step time so that elapsed lands often right around the hold threshold
      r = $urandom_range(0, 99);
      if (r < 40) cur_ms += $urandom_range(0, 40);
      else if (r < 70) cur_ms += time_ms_type'(int'(cfg_hold) + int'($urandom_range(0, 4)) - 2);
      else if (r < 95) cur_ms += $urandom_range(0, 2 * int'(cfg_hold) + 10);
      else cur_ms = $urandom;
      send_frame(fid, pg, key, cur_ms);
   endtask

   initial begin
      frame_id_type id_val;
      hold_ms_type  hold_val;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part on reset settings
      send_frame(11'h000, CodePageAudio, CodeUp, 32'd0);
      send_frame(11'h7FF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
      send_frame(cfg_id, CodePageAudio, 8'h00, 32'd10);
      send_frame(cfg_id, CodePageTel, CodeUp, 32'd100);
      sender_gap();
      send_frame(cfg_id, 8'h00, 8'h00, 32'd200);
      // press across the time wrap: 992, 1000, then 1001 ms elapsed
      send_frame(cfg_id, 8'hFF, CodeDown, 32'hFFFF_FF00);
      send_frame(cfg_id, CodePageAudio, CodeDown, 32'h0000_02E0);
      send_frame(cfg_id, CodePageTel, CodeDown, 32'h0000_02E8);
      sender_gap();
      send_frame(cfg_id, CodePageAudio, CodeDown, 32'h0000_02E9);
      send_frame(cfg_id, CodePageAudio, CodeDown, 32'h0001_0000);
      send_frame(cfg_id, CodePageAudio, 8'h00, 32'h0001_0001);
      send_frame(cfg_id, CodePageTel, CodeTelUp, 32'd5000);
      send_frame(cfg_id, CodePageTel, 8'h00, 32'd5001);
      send_frame(cfg_id, CodePageTel, CodeTelDown, 32'd6000);
      sender_gap();
      send_frame(cfg_id, CodePageTel, CodeTelDown, 32'd7001);
      send_frame(cfg_id, CodePageTel, 8'h00, 32'd7002);
      // unknown codes: tap and long give no event but clear the pending press
      send_frame(cfg_id, 8'h55, 8'h55, 32'd8000);
      send_frame(cfg_id, 8'h55, 8'h00, 32'd8001);
      send_frame(cfg_id, 8'hAA, 8'hAA, 32'd9000);
      send_frame(cfg_id, 8'hAA, 8'hAA, 32'd10001);
      send_frame(cfg_id, 8'hAA, 8'h00, 32'd10002);
      // code changes while held keep the first key and start time
      send_frame(cfg_id, CodePageAudio, CodeUp, 32'd11000);
      send_frame(cfg_id, CodePageAudio, CodeDown, 32'd11500);
      send_frame(cfg_id, CodePageAudio, CodeTelUp, 32'd12001);
      send_frame(cfg_id, CodePageAudio, 8'h00, 32'd12002);
      send_frame(cfg_id, CodePageAudio, CodeUp, 32'd13000);
      send_frame(cfg_id, CodePageAudio, CodeDown, 32'd13001);
      send_frame(cfg_id, CodePageAudio, 8'h00, 32'd13002);

      for (int phase = 0; phase < NumPhases; phase++) begin
         case (phase)
            0: begin
               id_val   = 11'h000;
               hold_val = 16'h0000;
            end
            1: begin
               id_val   = 11'h7FF;
               hold_val = 16'hFFFF;
            end
            2: begin
               id_val   = WatchedFrameIdReset;
               hold_val = LongPressMsReset;
            end
            default: begin
               id_val   = frame_id_type'($urandom);
               hold_val = ($urandom_range(0, 3) == 0) ? hold_ms_type'($urandom)
                                                      : hold_ms_type'($urandom_range(0, 200));
            end
         endcase
         set_config(id_val, hold_val);
         no_gaps = (phase == 3);
         cur_ms  = $urandom_range(0, 1) ? 32'hFFFF_FFFF - $urandom_range(0, 5000) : $urandom;
         for (int i = 0; i < PhaseItems; i++) begin
            if (i == PhaseItems / 2) drain();
            send_random_frame();
            sender_gap();
         end
      end

      drain();
      repeat (4) @(negedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
